>>> rtl/ss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ss_pkg: shared types and constants for the substring search core
// Command codes, register indexes, field widths and the structs that pass
// between the window chain, the match tracker and the top level.
// ----------------------------------------------------------------------------
package ss_pkg;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 4;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int POS_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 1'b1;

  // events handed to the tracker for the item accepted this cycle
  typedef struct packed {
    logic take_byte;
    logic end_item;
    logic win_eq;
  } track_ctl_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             too_long;
  } result_t;

endpackage

>>> rtl/substring_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search_core: streaming first-occurrence substring search
// Window of recent haystack bytes in a chain of cells, compared in parallel
// against the stored pattern on every byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per handshake:
//   cmd 0 writes pattern byte in_pattern_index, cmd 1 feeds a haystack byte,
//   cmd 2 ends the haystack and produces one result, cmd 3 is dropped.
//   Result channel (out_valid/out_ready) carries found, position, too_long.
//   Config port: cfg_we writes pattern_length (index 0) or start_position
//   (index 1) from cfg_wdata in the same cycle; write only while idle.
// Timing:
//   One item per cycle sustained while no end item is held off (see Stall).
//   The byte shifts into the cell chain and is compared in the same cycle,
//   so the match decision uses the pattern and registers of that cycle.
//   The result of an end item appears on out_valid the next cycle.
// Stall:
//   A single output register holds the result. While it is full and
//   out_ready is low, only an end item is held off; pattern and haystack
//   items keep flowing.
// Reset:
//   Synchronous, active low. Clears config registers, counters, match state and
//   the output valid. Pattern bytes are undefined until written.
// ----------------------------------------------------------------------------
module substring_search_core #(
  parameter int MAX_PATTERN  = 16,
  parameter int MAX_HAYSTACK = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input item channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ss_pkg::CMD_W-1:0]      in_cmd,
  input  logic [ss_pkg::IDX_W-1:0]      in_pattern_index,
  input  logic [ss_pkg::BYTE_W-1:0]     in_data_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [ss_pkg::POS_W-1:0]      out_position,
  output logic                          out_too_long,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [ss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // configuration registers
  logic [ss_pkg::LEN_W-1:0] plen_r;
  logic [ss_pkg::POS_W-1:0] start_r;
  logic [ss_pkg::LEN_W-1:0] ulen;

  // pattern store, written by cmd 0
  logic [MAX_PATTERN-1:0][ss_pkg::BYTE_W-1:0] pat_r;

  // cell chain
  logic [MAX_PATTERN-1:0][ss_pkg::BYTE_W-1:0] win;
  logic [MAX_PATTERN-1:0]                     cell_eq;

  logic               acc;
  logic               pat_acc;
  logic               byte_acc;
  logic               end_acc;
  logic               room;
  logic               shift_en;
  ss_pkg::track_ctl_t ctl;
  ss_pkg::result_t    res;

  logic            out_valid_r, out_valid_nxt;
  ss_pkg::result_t out_res_r;

  // only an end item needs the output register
  assign in_ready = (in_cmd != ss_pkg::CMD_END) || !out_valid_r || out_ready;

  assign acc      = in_valid && in_ready;
  assign pat_acc  = acc && (in_cmd == ss_pkg::CMD_PATTERN);
  assign byte_acc = acc && (in_cmd == ss_pkg::CMD_BYTE);
  assign end_acc  = acc && (in_cmd == ss_pkg::CMD_END);

  // lengths past the window size saturate
  always_comb begin
    if (32'(plen_r) > 32'(MAX_PATTERN)) begin
      ulen = ss_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      ulen = plen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= '0;
      start_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ss_pkg::REG_PATTERN_LENGTH: plen_r  <= cfg_wdata[ss_pkg::LEN_W-1:0];
        ss_pkg::REG_START_POSITION: start_r <= cfg_wdata[ss_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range pattern indexes are ignored
  always_ff @(posedge clk) begin
    if (pat_acc && (32'(in_pattern_index) < 32'(MAX_PATTERN))) begin
      pat_r[PIW'(in_pattern_index)] <= in_data_byte;
    end
  end

  // bytes past the haystack limit are dropped, window holds
  assign shift_en = byte_acc && room;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [ss_pkg::BYTE_W-1:0] din;
    if (j == 0) begin : g_head
      assign din = in_data_byte;
    end else begin : g_link
      assign din = win[j-1];
    end
    ss_cell #(
      .IDX         (j),
      .MAX_PATTERN (MAX_PATTERN)
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .din      (din),
      .pattern  (pat_r),
      .ulen     (ulen),
      .dout     (win[j]),
      .eq       (cell_eq[j])
    );
  end

  assign ctl.take_byte = byte_acc;
  assign ctl.end_item  = end_acc;
  assign ctl.win_eq    = &cell_eq;

  ss_track #(
    .MAX_HAYSTACK (MAX_HAYSTACK)
  ) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .ulen  (ulen),
    .start (start_r),
    .room  (room),
    .res   (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (end_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (end_acc) begin
      out_res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_res_r.found;
  assign out_position = out_res_r.position;
  assign out_too_long = out_res_r.too_long;

`ifndef NO_ASSERTIONS
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    end_acc |=> out_valid_r)
    else $error("end item did not load the output register");

  a_no_pos_without_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found) |-> (out_position == '0))
    else $error("position set on a result with no match");

  a_byte_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en |=> (win[0] == $past(in_data_byte)))
    else $error("haystack byte did not enter the head cell");

  a_end_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !end_acc)
    else $error("end item accepted over a held result");
`endif

endmodule

>>> rtl/ss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ss_cell: one window cell
// Holds one haystack byte, passes it to the next cell on each shift and
// compares the byte it is about to take with its aligned pattern byte.
// ----------------------------------------------------------------------------
module ss_cell #(
  parameter int IDX         = 0,
  parameter int MAX_PATTERN = 16
) (
  input  logic                                     clk,
  input  logic                                     shift_en,
  input  logic [ss_pkg::BYTE_W-1:0]                din,
  input  logic [MAX_PATTERN-1:0][ss_pkg::BYTE_W-1:0] pattern,
  input  logic [ss_pkg::LEN_W-1:0]                 ulen,
  output logic [ss_pkg::BYTE_W-1:0]                dout,
  output logic                                     eq
);

  localparam int PIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [ss_pkg::BYTE_W-1:0] byte_r;
  logic [6:0]                sel_full;
  logic [PIW-1:0]            sel;
  logic                      used;

  // cell IDX pairs with pattern byte (ulen - 1 - IDX)
  always_comb begin
    sel_full = 7'(ulen) - 7'(IDX) - 7'd1;
    sel      = sel_full[PIW-1:0];
    used     = 7'(ulen) > 7'(IDX);
    eq       = !used || (din == pattern[sel]);
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= din;
    end
  end

  assign dout = byte_r;

endmodule

>>> rtl/ss_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ss_track: byte count and first-match tracker
// Counts haystack bytes, keeps the earliest qualifying match start and the
// overflow flag, and forms the result for an end item.
// ----------------------------------------------------------------------------
module ss_track #(
  parameter int MAX_HAYSTACK = 65536
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ss_pkg::track_ctl_t        ctl,
  input  logic [ss_pkg::LEN_W-1:0]  ulen,
  input  logic [ss_pkg::POS_W-1:0]  start,
  output logic                      room,
  output ss_pkg::result_t           res
);

  localparam int CW   = $clog2(MAX_HAYSTACK + 1);
  localparam int CMPW = (CW > ss_pkg::POS_W) ? CW : ss_pkg::POS_W;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          mseen_r, mseen_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] mstart_r;
  logic [CW-1:0] cnt_inc;
  logic          cand_ok;
  logic          hit;
  logic          empty;

  always_comb begin
    cnt_inc = cnt_r + CW'(1);
    room    = cnt_r < CW'(MAX_HAYSTACK);
    // start of the candidate (cnt_inc - ulen) is not before start
    cand_ok = (CMPW+1)'(cnt_inc) >= ((CMPW+1)'(ulen) + (CMPW+1)'(start));
    hit     = ctl.take_byte && room && !mseen_r && (ulen != '0) &&
              ctl.win_eq && cand_ok;
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    mseen_nxt = mseen_r;
    ovf_nxt   = ovf_r;
    priority if (ctl.end_item) begin
      cnt_nxt   = '0;
      mseen_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end else if (ctl.take_byte) begin
      if (!room) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_inc;
        if (hit) begin
          mseen_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      mseen_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      mseen_r <= mseen_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // only read while mseen_r is set
  always_ff @(posedge clk) begin
    if (hit) begin
      mstart_r <= cnt_inc - CW'(ulen);
    end
  end

  always_comb begin
    empty        = (ulen == '0);
    res.too_long = ovf_r;
    if (empty) begin
      res.found    = CMPW'(start) <= CMPW'(cnt_r);
      res.position = res.found ? start : '0;
    end else begin
      res.found    = mseen_r;
      res.position = mseen_r ? ss_pkg::POS_W'(mstart_r) : '0;
    end
  end

endmodule

>>> tb/substring_search_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search_core_tb: self-checking bench for the substring search core
// A driver streams items from a queue, a scoreboard predicts every result at
// item acceptance, and a monitor compares each result field by field. Directed
// searches cover the corners (empty and saturated patterns, start past the
// haystack, register changes mid-stream); random searches with planted
// matches and random stalls follow.
// ----------------------------------------------------------------------------
module substring_search_core_tb;

  localparam int PAT_SLOTS = 16;
  localparam int HAY_LIMIT = 65536;
  localparam logic [ss_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [ss_pkg::CMD_W-1:0]  cmd;
    logic [ss_pkg::IDX_W-1:0]  idx;
    logic [ss_pkg::BYTE_W-1:0] data;
  } search_item_t;

  // DUT ports; the inputs are known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ss_pkg::CMD_W-1:0] in_cmd = '0;
  logic [ss_pkg::IDX_W-1:0] in_pattern_index = '0;
  logic [ss_pkg::BYTE_W-1:0] in_data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic [ss_pkg::POS_W-1:0] out_position;
  logic out_too_long;
  logic cfg_we = 1'b0;
  logic [ss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  substring_search_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_pattern_index(in_pattern_index), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_position(out_position), .out_too_long(out_too_long),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // stimulus and scoreboard storage
  search_item_t     pending_items[$];
  ss_pkg::result_t  expected_results[$];
  int               mismatches = 0;

  // predictor copy of the block state
  logic [ss_pkg::BYTE_W-1:0] pat_mem[PAT_SLOTS];
  logic [ss_pkg::BYTE_W-1:0] hay_window[PAT_SLOTS];  // entry 0 holds the newest byte
  int unsigned               hay_count = 0;
  bit                        hit_seen = 1'b0;
  logic [ss_pkg::POS_W-1:0]  hit_pos = '0;
  bit                        hay_overflow = 1'b0;
  logic [ss_pkg::LEN_W-1:0]  len_reg = '0;
  logic [ss_pkg::POS_W-1:0]  start_reg = '0;

  // generator view of the pattern, updated as writes are queued
  logic [ss_pkg::BYTE_W-1:0] pat_shadow[PAT_SLOTS];

  // idle / stall control
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  search_item_t next_item;

  int items_sent = 0;
  int searches_sent = 0;
  int hay_len, k, nsearch, rlen;

  initial begin
    forever #2 clk = ~clk;
  end

  // Generous fixed limit: ~600 items with idle and stall bursts
  initial begin
    #400_000;
    $display("[substring_search_core] ERROR");
    $finish;
  end

  task automatic note_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic void clear_search();
    for (int i = 0; i < PAT_SLOTS; i++) hay_window[i] = '0;
    hay_count = 0;
    hit_seen = 1'b0;
    hit_pos = '0;
    hay_overflow = 1'b0;
  endfunction

  // Advance the predictor by one accepted item; end items queue a result.
  function automatic void search_step(input logic [ss_pkg::CMD_W-1:0] cmd,
                                      input logic [ss_pkg::IDX_W-1:0] idx,
                                      input logic [ss_pkg::BYTE_W-1:0] b);
    int              eff;
    int              cand;
    bit              same;
    ss_pkg::result_t res;
    eff = (len_reg > PAT_SLOTS) ? PAT_SLOTS : int'(len_reg);
    case (cmd)
      ss_pkg::CMD_PATTERN: begin
        pat_mem[idx] = b;
      end
      ss_pkg::CMD_BYTE: begin
        if (hay_count >= HAY_LIMIT) begin
          // bytes past the limit are dropped but flagged
          hay_overflow = 1'b1;
        end else begin
          for (int i = PAT_SLOTS - 1; i > 0; i--) hay_window[i] = hay_window[i-1];
          hay_window[0] = b;
          hay_count++;
          if (!hit_seen && eff != 0 && hay_count >= eff) begin
            cand = hay_count - eff;
            if (cand >= start_reg) begin
              same = 1'b1;
              for (int j = 0; j < eff; j++)
                if (hay_window[eff-1-j] != pat_mem[j]) same = 1'b0;
              if (same) begin
                hit_seen = 1'b1;
                hit_pos = cand[ss_pkg::POS_W-1:0];
              end
            end
          end
        end
      end
      ss_pkg::CMD_END: begin
        if (eff == 0) begin
          // empty pattern matches at the start position if it lies in range
          res.found = (start_reg <= hay_count);
          res.position = res.found ? start_reg : '0;
        end else begin
          res.found = hit_seen;
          res.position = hit_seen ? hit_pos : '0;
        end
        res.too_long = hay_overflow;
        expected_results.push_back(res);
        clear_search();
      end
      default: ;  // unused command is dropped
    endcase
  endfunction

  task automatic push_item(input logic [ss_pkg::CMD_W-1:0] cmd,
                           input logic [ss_pkg::IDX_W-1:0] idx,
                           input logic [ss_pkg::BYTE_W-1:0] data);
    pending_items.push_back('{cmd: cmd, idx: idx, data: data});
    if (cmd == ss_pkg::CMD_PATTERN) pat_shadow[idx] = data;
    if (cmd == ss_pkg::CMD_END) searches_sent++;
    items_sent++;
  endtask

  // Both registers are written on back-to-back edges; only called while idle.
  task automatic write_regs(input logic [ss_pkg::CFG_DATA_W-1:0] len_word,
                            input logic [ss_pkg::CFG_DATA_W-1:0] start_word);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ss_pkg::REG_PATTERN_LENGTH;
    cfg_wdata <= len_word;
    @(posedge clk);
    cfg_index <= ss_pkg::REG_START_POSITION;
    cfg_wdata <= start_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    len_reg = len_word[ss_pkg::LEN_W-1:0];
    start_reg = start_word[ss_pkg::POS_W-1:0];
  endtask

  // Wait until every queued item is taken and every result has come back,
  // then let the block settle. Sampled on the falling edge so the driver's
  // updates of the same rising edge are visible.
  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_valid || out_valid ||
           expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One search: haystack of random bytes drawn mostly from the pattern's own
  // alphabet, optionally with the pattern planted, sprinkled with pattern
  // rewrites and dropped commands, then the end item.
  task automatic queue_search(input int hlen, input bit plant);
    int eff;
    int at;
    logic [ss_pkg::BYTE_W-1:0] b;
    eff = (len_reg > PAT_SLOTS) ? PAT_SLOTS : int'(len_reg);
    at = (eff > 0 && hlen >= eff) ? $urandom_range(0, hlen - eff) : -1;
    for (int q = 0; q < hlen; q++) begin
      if (plant && at >= 0 && q >= at && q < at + eff)
        b = pat_shadow[q-at];
      else if ($urandom_range(0, 3) != 0)
        b = pat_shadow[$urandom_range(0, 3)];
      else
        b = ss_pkg::BYTE_W'($urandom_range(0, 255));
      push_item(ss_pkg::CMD_BYTE, '0, b);
      if ($urandom_range(0, 29) == 0)
        push_item(ss_pkg::CMD_PATTERN, ss_pkg::IDX_W'($urandom_range(0, PAT_SLOTS - 1)),
                  ss_pkg::BYTE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 29) == 0)
        push_item(CMD_UNUSED, ss_pkg::IDX_W'($urandom_range(0, 15)),
                  ss_pkg::BYTE_W'($urandom_range(0, 255)));
    end
    push_item(ss_pkg::CMD_END, ss_pkg::IDX_W'($urandom_range(0, 15)),
              ss_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // Driver: hold valid until taken, predict on acceptance, insert idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) search_step(in_cmd, in_pattern_index, in_data_byte);
      if (!in_valid || in_ready) begin
        if (gap_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 8);
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_cmd <= next_item.cmd;
          in_pattern_index <= next_item.idx;
          in_data_byte <= next_item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction and
  // throttle the result channel with random stall bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result with no pending search");
        end else begin
          if (out_found !== expected_results[0].found)
            note_mismatch($sformatf("found %0b, want %0b", out_found,
                                    expected_results[0].found));
          if (out_position !== expected_results[0].position)
            note_mismatch($sformatf("position %0d, want %0d", out_position,
                                    expected_results[0].position));
          if (out_too_long !== expected_results[0].too_long)
            note_mismatch($sformatf("too_long %0b, want %0b", out_too_long,
                                    expected_results[0].too_long));
          void'(expected_results.pop_front());
        end
      end
      if (stall_left == 0 && stalls_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 8);
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    for (int i = 0; i < PAT_SLOTS; i++) begin
      pat_mem[i] = '0;
      pat_shadow[i] = '0;
      hay_window[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: empty pattern, start 0 -> empty haystack matches at 0.
    push_item(ss_pkg::CMD_END, '0, '0);
    push_item(CMD_UNUSED, 4'hF, 8'hFF);
    // Fill the whole pattern store before any compare can read it.
    for (k = 0; k < PAT_SLOTS; k++)
      push_item(ss_pkg::CMD_PATTERN, ss_pkg::IDX_W'(k),
                (k == 0) ? 8'h00 : (k == 1) ? 8'hFF :
                (k == 2) ? 8'h5A : ss_pkg::BYTE_W'(8'h30 + k));
    wait_quiet();

    // First match sits before the start position; the second one counts.
    write_regs(17'd3, 17'd2);
    push_item(ss_pkg::CMD_BYTE, '0, 8'h00);
    push_item(ss_pkg::CMD_BYTE, '0, 8'hFF);
    push_item(ss_pkg::CMD_BYTE, '0, 8'h5A);
    push_item(ss_pkg::CMD_BYTE, '0, 8'h07);
    push_item(ss_pkg::CMD_BYTE, '0, 8'h00);
    push_item(ss_pkg::CMD_BYTE, '0, 8'hFF);
    push_item(ss_pkg::CMD_BYTE, '0, 8'h5A);
    push_item(ss_pkg::CMD_END, '0, '0);
    wait_quiet();

    // Length beyond the store saturates to the full 16-byte pattern.
    write_regs(17'd31, 17'd0);
    for (k = 0; k < 3; k++) push_item(ss_pkg::CMD_BYTE, '0, 8'h77);
    for (k = 0; k < PAT_SLOTS; k++) push_item(ss_pkg::CMD_BYTE, '0, pat_shadow[k]);
    push_item(ss_pkg::CMD_END, '0, '0);
    wait_quiet();

    // Only match starts before start_position -> nothing found.
    write_regs(17'd2, 17'd5);
    push_item(ss_pkg::CMD_BYTE, '0, 8'h00);
    push_item(ss_pkg::CMD_BYTE, '0, 8'hFF);
    push_item(ss_pkg::CMD_END, '0, '0);
    wait_quiet();

    // Empty pattern with start far past the haystack.
    write_regs(17'd0, 17'h1FFFF);
    push_item(ss_pkg::CMD_BYTE, '0, 8'h00);
    push_item(ss_pkg::CMD_BYTE, '0, 8'hFF);
    push_item(ss_pkg::CMD_END, '0, '0);
    wait_quiet();

    // Registers change halfway through a haystack.
    write_regs(17'd2, 17'd0);
    push_item(ss_pkg::CMD_BYTE, '0, 8'h01);
    push_item(ss_pkg::CMD_BYTE, '0, 8'h02);
    wait_quiet();
    write_regs(17'd1, 17'd1);
    push_item(ss_pkg::CMD_BYTE, '0, 8'h00);
    push_item(ss_pkg::CMD_END, '0, '0);
    wait_quiet();

    // Random phases: new settings each time, one to four searches per setting.
    items_sent = 0;
    searches_sent = 0;
    while (items_sent < 500 || searches_sent < 40) begin
      gaps_on = (items_sent < 420) && ($urandom_range(0, 3) != 0);
      stalls_on = (items_sent < 420) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       rlen = 0;
        1:       rlen = PAT_SLOTS;
        2:       rlen = $urandom_range(PAT_SLOTS + 1, 31);
        default: rlen = $urandom_range(1, 6);
      endcase
      // upper bits of the length word are don't-care
      write_regs({12'($urandom_range(0, 4095)), rlen[ss_pkg::LEN_W-1:0]},
                 ($urandom_range(0, 7) == 0)
                   ? ss_pkg::CFG_DATA_W'($urandom_range(0, 17'h1FFFF))
                   : ss_pkg::CFG_DATA_W'($urandom_range(0, 10)));
      nsearch = $urandom_range(1, 4);
      for (k = 0; k < nsearch; k++) begin
        if ($urandom_range(0, 3) == 0)
          push_item(ss_pkg::CMD_PATTERN, ss_pkg::IDX_W'($urandom_range(0, PAT_SLOTS - 1)),
                    ss_pkg::BYTE_W'($urandom_range(0, 255)));
        hay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                              : $urandom_range(0, 16);
        queue_search(hay_len, 1'($urandom_range(0, 1)));
      end
      wait_quiet();
    end

    // Closing search streamed with no idling on either side.
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (8) @(posedge clk);
    queue_search(16, 1'b1);
    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("[substring_search_core] OK");
    else
      $display("[substring_search_core] ERROR");
    $finish;
  end

endmodule
